// ===== rtl/core/look_at_view_matrix_core_macros.svh =====
// ----------------------------------------------------------------------------
// Look-at view matrix core: assertion macros
// Shared property forms for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef LOOK_AT_VIEW_MATRIX_CORE_MACROS_SVH
`define LOOK_AT_VIEW_MATRIX_CORE_MACROS_SVH

// Same-cycle implication.
`define LAVM_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define LAVM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/lavm_pkg.sv =====
// ----------------------------------------------------------------------------
// Look-at view matrix package
// Payload types of the request and response channels and shared codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lavm_pkg;

   localparam int DATA_W = 32;

   // Row code of the constant last matrix row
   localparam logic [1:0] ROW_LAST = 2'd3;

   typedef struct packed {
      logic signed [DATA_W-1:0] from_x;
      logic signed [DATA_W-1:0] from_y;
      logic signed [DATA_W-1:0] from_z;
      logic signed [DATA_W-1:0] to_x;
      logic signed [DATA_W-1:0] to_y;
      logic signed [DATA_W-1:0] to_z;
      logic signed [DATA_W-1:0] up_x;
      logic signed [DATA_W-1:0] up_y;
      logic signed [DATA_W-1:0] up_z;
   } req_type;

   typedef struct packed {
      logic [1:0]               row_index;
      logic signed [DATA_W-1:0] col0;
      logic signed [DATA_W-1:0] col1;
      logic signed [DATA_W-1:0] col2;
      logic signed [DATA_W-1:0] col3;
      logic                     last_row;
      logic                     degenerate;
   } rsp_type;

endpackage

// ===== rtl/core/lavm_chan_if.sv =====
// ----------------------------------------------------------------------------
// Look-at view matrix channels
// Valid/ready channels for camera requests and matrix row responses.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lavm_req_if;
   logic              valid;
   logic              ready;
   lavm_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface lavm_rsp_if;
   logic              valid;
   logic              ready;
   lavm_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/look_at_view_matrix_core.sv =====
// ----------------------------------------------------------------------------
// Look-at view matrix core
// Builds a 4x4 view matrix from eye, target and up in signed fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one camera (eye, target, up) per transfer. rsp_chan
//   returns the matrix as four row transfers, row 0 first; last_row marks
//   row 3 and degenerate is set on all four rows when forward or up is zero.
//   The first row leaves the output register after the normalizer and frame
//   pipelines; rows follow one per cycle while the receiver is ready.
//   Each camera occupies the single response channel for its four row
//   transfers. The datapath is a fully pipelined chain (square root one
//   bit per stage, division one bit per stage, then cross products) that
//   can take a request in every cycle unless a finished matrix waits for the output register.
//   Reset clears all valid bits and the row counter; no result is pending.
//   When the receiver stalls, the current row holds and the pipeline keeps
//   filling bubbles until the output register is needed, then stops as a
//   whole; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "look_at_view_matrix_core_macros.svh"

module look_at_view_matrix_core #(
   parameter int FRACTION_BITS = 16
) (
   input logic        clock,
   input logic        reset,
   lavm_req_if.sink   req_chan,
   lavm_rsp_if.source rsp_chan
);

   localparam int NW = FRACTION_BITS + 2;
   localparam logic signed [31:0] ONE = 32'(1) << FRACTION_BITS;

   logic                 en;
   logic                 take;
   logic                 fin;
   logic                 load;

   logic signed [31:0]   from_vec [3];
   logic signed [31:0]   to_vec [3];
   logic signed [31:0]   up_vec [3];
   logic signed [31:0]   zero_vec [3];

   logic                 fwd_valid;
   logic signed [NW-1:0] fwd_vec [3];
   logic                 fwd_zero;
   logic [95:0]          fwd_tag;
   logic                 up_valid;
   logic signed [NW-1:0] upn_vec [3];
   logic                 up_zero;
   logic signed [31:0]   eye_vec [3];

   logic                 frm_valid;
   logic signed [31:0]   frm_rows [3][4];
   logic                 frm_degen;

   logic                 hold_v_ff;
   logic                 hold_v_in;
   logic                 hold_dg_ff;
   logic signed [31:0]   hold_rows_ff [3][4];
   logic [1:0]           cnt_ff;
   logic [1:0]           cnt_in;

   // Unpack the request
   always_comb begin
      from_vec[0] = req_chan.data.from_x;
      from_vec[1] = req_chan.data.from_y;
      from_vec[2] = req_chan.data.from_z;
      to_vec[0] = req_chan.data.to_x;
      to_vec[1] = req_chan.data.to_y;
      to_vec[2] = req_chan.data.to_z;
      up_vec[0] = req_chan.data.up_x;
      up_vec[1] = req_chan.data.up_y;
      up_vec[2] = req_chan.data.up_z;
      for (int i = 0; i < 3; i++) begin
         zero_vec[i] = '0;
         eye_vec[i] = fwd_tag[32*i +: 32];
      end
   end

   // Advance the pipeline unless a full matrix would overwrite a held one
   assign take = rsp_chan.valid & rsp_chan.ready;
   assign fin = take & (cnt_ff == lavm_pkg::ROW_LAST);
   assign en = ~frm_valid | ~hold_v_ff | fin;
   assign load = en & frm_valid;
   assign req_chan.ready = en;

   lavm_norm #(
      .FRACTION_BITS (FRACTION_BITS),
      .TAG_W         (96)
   ) u_fwd (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_chan.valid),
      .in_a      (from_vec),
      .in_b      (to_vec),
      .in_tag    ({from_vec[2], from_vec[1], from_vec[0]}),
      .out_valid (fwd_valid),
      .out_vec   (fwd_vec),
      .out_zero  (fwd_zero),
      .out_tag   (fwd_tag)
   );

   lavm_norm #(
      .FRACTION_BITS (FRACTION_BITS),
      .TAG_W         (1)
   ) u_up (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_chan.valid),
      .in_a      (zero_vec),
      .in_b      (up_vec),
      .in_tag    (1'b0),
      .out_valid (up_valid),
      .out_vec   (upn_vec),
      .out_zero  (up_zero),
      .out_tag   ()
   );

   lavm_frame #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_frame (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (fwd_valid),
      .in_fwd    (fwd_vec),
      .in_upn    (upn_vec),
      .in_from   (eye_vec),
      .in_degen  (fwd_zero | up_zero),
      .out_valid (frm_valid),
      .out_rows  (frm_rows),
      .out_degen (frm_degen)
   );

   // Output register and row counter
   always_comb begin
      hold_v_in = load ? 1'b1 : (fin ? 1'b0 : hold_v_ff);
      cnt_in = load ? 2'd0 : (take ? cnt_ff + 2'd1 : cnt_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_v_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         hold_v_ff <= hold_v_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         hold_rows_ff <= frm_rows;
         hold_dg_ff <= frm_degen;
      end
   end

   // Drive the current row
   always_comb begin
      rsp_chan.valid = hold_v_ff;
      rsp_chan.data.row_index = cnt_ff;
      rsp_chan.data.last_row = (cnt_ff == lavm_pkg::ROW_LAST);
      rsp_chan.data.degenerate = hold_dg_ff;
      if (cnt_ff == lavm_pkg::ROW_LAST) begin
         rsp_chan.data.col0 = '0;
         rsp_chan.data.col1 = '0;
         rsp_chan.data.col2 = '0;
         rsp_chan.data.col3 = hold_dg_ff ? '0 : ONE;
      end else begin
         rsp_chan.data.col0 = hold_rows_ff[cnt_ff][0];
         rsp_chan.data.col1 = hold_rows_ff[cnt_ff][1];
         rsp_chan.data.col2 = hold_rows_ff[cnt_ff][2];
         rsp_chan.data.col3 = hold_rows_ff[cnt_ff][3];
      end
   end

   // Checks
   `LAVM_ASSERT_SAME(a_lane_sync, clock, reset, 1'b1, fwd_valid == up_valid, "normalizer lanes out of step")
   `LAVM_ASSERT_NEXT(a_row_step, clock, reset, take && (cnt_ff != lavm_pkg::ROW_LAST), cnt_ff == $past(cnt_ff) + 2'd1, "row counter skipped")
   `LAVM_ASSERT_NEXT(a_drain, clock, reset, fin && !load, !rsp_chan.valid, "matrix repeated after last row")
   `LAVM_ASSERT_SAME(a_degen_zero, clock, reset, rsp_chan.valid && rsp_chan.data.degenerate, (rsp_chan.data.col0 == '0) && (rsp_chan.data.col3 == '0), "degenerate row not zero")

endmodule

// ===== rtl/core/lavm_norm.sv =====
// ----------------------------------------------------------------------------
// Vector normalizer pipeline
// Forms b - a, scales it, takes the integer square root of its squared length
// one result bit per stage and divides each component one quotient bit per
// stage. A side tag travels with each vector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lavm_norm #(
   parameter int FRACTION_BITS = 16,
   parameter int TAG_W = 1
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            en,
   input  logic                            in_valid,
   input  logic signed [31:0]              in_a [3],
   input  logic signed [31:0]              in_b [3],
   input  logic [TAG_W-1:0]                in_tag,
   output logic                            out_valid,
   output logic signed [FRACTION_BITS+1:0] out_vec [3],
   output logic                            out_zero,
   output logic [TAG_W-1:0]                out_tag
);

   localparam int NW = FRACTION_BITS + 2;
   localparam int QW = FRACTION_BITS + 1;
   localparam int SQ_STEPS = 32;
   localparam int TOTAL = SQ_STEPS + QW + 6;
   localparam logic [4:0] TOP_BIT = 5'd29;

   logic [TOTAL-1:0] vld_ff;

   logic             neg1_ff [3];
   logic [31:0]      mag1_ff [3];
   logic [TAG_W-1:0] tag1_ff;
   logic             neg2_ff [3];
   logic [31:0]      mag2_ff [3];
   logic [1:0]       rs2_ff;
   logic [4:0]       ls2_ff;
   logic             zero2_ff;
   logic [TAG_W-1:0] tag2_ff;
   logic             neg3_ff [3];
   logic [29:0]      sm3_ff [3];
   logic             zero3_ff;
   logic [TAG_W-1:0] tag3_ff;
   logic             neg4_ff [3];
   logic [29:0]      sm4_ff [3];
   logic [59:0]      sq4_ff [3];
   logic             zero4_ff;
   logic [TAG_W-1:0] tag4_ff;

   // Square root stage registers, index 0 holds the squared length
   logic [62:0]      qx_ff [0:SQ_STEPS];
   logic [62:0]      qr_ff [0:SQ_STEPS];
   logic [29:0]      qm_ff [0:SQ_STEPS][3];
   logic             qn_ff [0:SQ_STEPS][3];
   logic             qz_ff [0:SQ_STEPS];
   logic [TAG_W-1:0] qt_ff [0:SQ_STEPS];

   // Divider stage registers
   logic [30:0]      dl_ff [0:QW-1];
   logic [31:0]      dr_ff [0:QW-1][3];
   logic [QW-1:0]    dq_ff [0:QW-1][3];
   logic             dn_ff [0:QW-1][3];
   logic             dz_ff [0:QW-1];
   logic [TAG_W-1:0] dt_ff [0:QW-1];

   logic signed [32:0] diff_in [3];
   logic [31:0]        mag_in [3];
   logic [31:0]        or_in;
   logic [4:0]         msb_in;
   logic [1:0]         rs_in;
   logic [4:0]         ls_in;
   logic [29:0]        sm_in [3];
   logic [59:0]        sq_in [3];

   // Advance valid bits alongside the data
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[TOTAL-2:0], in_valid};
      end
   end

   assign out_valid = vld_ff[TOTAL-1];

   // Difference, magnitude, scale search, scaling and squares
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         diff_in[i] = 33'(in_b[i]) - 33'(in_a[i]);
         mag_in[i] = diff_in[i][32] ? 32'(-diff_in[i]) : 32'(diff_in[i]);
      end
      or_in = mag1_ff[0] | mag1_ff[1] | mag1_ff[2];
      msb_in = '0;
      for (int b = 0; b < 32; b++) begin
         if (or_in[b]) msb_in = 5'(b);
      end
      rs_in = (msb_in >= TOP_BIT) ? 2'(msb_in - TOP_BIT) : 2'd0;
      ls_in = (msb_in < TOP_BIT) ? TOP_BIT - msb_in : 5'd0;
      for (int i = 0; i < 3; i++) begin
         sm_in[i] = 30'((mag2_ff[i] >> rs2_ff) << ls2_ff);
         sq_in[i] = 60'(sm3_ff[i]) * 60'(sm3_ff[i]);
      end
   end

   // Front stages up to the squared length
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            neg1_ff[i] <= diff_in[i][32];
            mag1_ff[i] <= mag_in[i];
            neg2_ff[i] <= neg1_ff[i];
            mag2_ff[i] <= mag1_ff[i];
            neg3_ff[i] <= neg2_ff[i];
            sm3_ff[i] <= sm_in[i];
            neg4_ff[i] <= neg3_ff[i];
            sm4_ff[i] <= sm3_ff[i];
            sq4_ff[i] <= sq_in[i];
            qm_ff[0][i] <= sm4_ff[i];
            qn_ff[0][i] <= neg4_ff[i];
         end
         tag1_ff <= in_tag;
         rs2_ff <= rs_in;
         ls2_ff <= ls_in;
         zero2_ff <= (or_in == '0);
         tag2_ff <= tag1_ff;
         zero3_ff <= zero2_ff;
         tag3_ff <= tag2_ff;
         zero4_ff <= zero3_ff;
         tag4_ff <= tag3_ff;
         qx_ff[0] <= 63'(sq4_ff[0]) + 63'(sq4_ff[1]) + 63'(sq4_ff[2]);
         qr_ff[0] <= '0;
         qz_ff[0] <= zero4_ff;
         qt_ff[0] <= tag4_ff;
      end
   end

   // Square root, one result bit per stage
   for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
      localparam logic [62:0] BIT_VAL = 63'(1) << (62 - 2 * k);
      logic [62:0] trial;
      logic        ge;

      assign trial = qr_ff[k] + BIT_VAL;
      assign ge = (qx_ff[k] >= trial);

      always_ff @(posedge clock) begin
         if (en) begin
            qx_ff[k+1] <= ge ? qx_ff[k] - trial : qx_ff[k];
            qr_ff[k+1] <= ge ? (qr_ff[k] >> 1) + BIT_VAL : qr_ff[k] >> 1;
            for (int i = 0; i < 3; i++) begin
               qm_ff[k+1][i] <= qm_ff[k][i];
               qn_ff[k+1][i] <= qn_ff[k][i];
            end
            qz_ff[k+1] <= qz_ff[k];
            qt_ff[k+1] <= qt_ff[k];
         end
      end
   end

   // Divide each magnitude by the length, one quotient bit per stage
   for (genvar j = 0; j < QW; j++) begin : g_div
      logic [30:0]      l_src;
      logic [31:0]      r_src [3];
      logic [QW-1:0]    q_src [3];
      logic             n_src [3];
      logic             z_src;
      logic [TAG_W-1:0] t_src;
      logic [31:0]      t [3];
      logic             ge [3];

      if (j == 0) begin : g_first
         always_comb begin
            l_src = qr_ff[SQ_STEPS][30:0];
            z_src = qz_ff[SQ_STEPS];
            t_src = qt_ff[SQ_STEPS];
            for (int i = 0; i < 3; i++) begin
               r_src[i] = 32'(qm_ff[SQ_STEPS][i]);
               q_src[i] = '0;
               n_src[i] = qn_ff[SQ_STEPS][i];
            end
         end
      end else begin : g_next
         always_comb begin
            l_src = dl_ff[j-1];
            z_src = dz_ff[j-1];
            t_src = dt_ff[j-1];
            for (int i = 0; i < 3; i++) begin
               r_src[i] = dr_ff[j-1][i] << 1;
               q_src[i] = dq_ff[j-1][i];
               n_src[i] = dn_ff[j-1][i];
            end
         end
      end

      always_comb begin
         for (int i = 0; i < 3; i++) begin
            t[i] = r_src[i];
            ge[i] = (t[i] >= 32'(l_src));
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            for (int i = 0; i < 3; i++) begin
               dr_ff[j][i] <= ge[i] ? t[i] - 32'(l_src) : t[i];
               dq_ff[j][i] <= {q_src[i][QW-2:0], ge[i]};
               dn_ff[j][i] <= n_src[i];
            end
            dl_ff[j] <= l_src;
            dz_ff[j] <= z_src;
            dt_ff[j] <= t_src;
         end
      end
   end

   // Apply signs
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            out_vec[i] <= dn_ff[QW-1][i] ? -NW'(dq_ff[QW-1][i]) : NW'(dq_ff[QW-1][i]);
         end
         out_zero <= dz_ff[QW-1];
         out_tag <= dt_ff[QW-1];
      end
   end

endmodule

// ===== rtl/core/lavm_frame.sv =====
// ----------------------------------------------------------------------------
// View frame pipeline
// Builds left = forward x up and trueup = left x forward, then the
// translation terms -(row . from), and saturates every element.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lavm_frame #(
   parameter int FRACTION_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            en,
   input  logic                            in_valid,
   input  logic signed [FRACTION_BITS+1:0] in_fwd [3],
   input  logic signed [FRACTION_BITS+1:0] in_upn [3],
   input  logic signed [31:0]              in_from [3],
   input  logic                            in_degen,
   output logic                            out_valid,
   output logic signed [31:0]              out_rows [3][4],
   output logic                            out_degen
);

   localparam int NW = FRACTION_BITS + 2;
   localparam int LW = FRACTION_BITS + 3;
   localparam int RW = FRACTION_BITS + 4;
   localparam int PW = 2 * NW;
   localparam int XW = LW + NW;
   localparam int TW = RW + 32;
   localparam int SW = TW - FRACTION_BITS + 2;
   localparam int STAGES = 6;
   localparam int NXT [3] = '{1, 2, 0};
   localparam int PRV [3] = '{2, 0, 1};

   logic [STAGES-1:0] vld_ff;

   logic signed [PW-1:0] b1_p_ff [3][2];
   logic signed [NW-1:0] b1_f_ff [3];
   logic signed [31:0]   b1_fr_ff [3];
   logic                 b1_dg_ff;
   logic signed [LW-1:0] b2_l_ff [3];
   logic signed [NW-1:0] b2_f_ff [3];
   logic signed [31:0]   b2_fr_ff [3];
   logic                 b2_dg_ff;
   logic signed [XW-1:0] b3_p_ff [3][2];
   logic signed [LW-1:0] b3_l_ff [3];
   logic signed [NW-1:0] b3_f_ff [3];
   logic signed [31:0]   b3_fr_ff [3];
   logic                 b3_dg_ff;
   logic signed [RW-1:0] b4_t_ff [3];
   logic signed [LW-1:0] b4_l_ff [3];
   logic signed [NW-1:0] b4_f_ff [3];
   logic signed [31:0]   b4_fr_ff [3];
   logic                 b4_dg_ff;
   logic signed [RW-1:0] b5_r_ff [3][3];
   logic signed [TW-1:0] b5_tr_ff [3][3];
   logic                 b5_dg_ff;

   logic signed [PW:0]   d1_in [3];
   logic signed [XW:0]   d3_in [3];
   logic signed [RW-1:0] row_in [3][3];
   logic signed [SW-1:0] sum_in [3];

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (v < -64'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = 32'(v);
      end
      return r;
   endfunction

   // Advance valid bits alongside the data
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[STAGES-2:0], in_valid};
      end
   end

   assign out_valid = vld_ff[STAGES-1];

   // Cross differences, row assembly and translation sums
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         d1_in[i] = (PW+1)'(b1_p_ff[i][0]) - (PW+1)'(b1_p_ff[i][1]);
         d3_in[i] = (XW+1)'(b3_p_ff[i][0]) - (XW+1)'(b3_p_ff[i][1]);
         row_in[0][i] = RW'(b4_l_ff[i]);
         row_in[1][i] = b4_t_ff[i];
         row_in[2][i] = -RW'(b4_f_ff[i]);
      end
      for (int k = 0; k < 3; k++) begin
         sum_in[k] = SW'(b5_tr_ff[k][0] >>> FRACTION_BITS)
                   + SW'(b5_tr_ff[k][1] >>> FRACTION_BITS)
                   + SW'(b5_tr_ff[k][2] >>> FRACTION_BITS);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         // forward x up products
         for (int i = 0; i < 3; i++) begin
            b1_p_ff[i][0] <= PW'(in_fwd[NXT[i]]) * PW'(in_upn[PRV[i]]);
            b1_p_ff[i][1] <= PW'(in_fwd[PRV[i]]) * PW'(in_upn[NXT[i]]);
            b1_f_ff[i] <= in_fwd[i];
            b1_fr_ff[i] <= in_from[i];
         end
         b1_dg_ff <= in_degen;
         // left
         for (int i = 0; i < 3; i++) begin
            b2_l_ff[i] <= LW'(d1_in[i] >>> FRACTION_BITS);
            b2_f_ff[i] <= b1_f_ff[i];
            b2_fr_ff[i] <= b1_fr_ff[i];
         end
         b2_dg_ff <= b1_dg_ff;
         // left x forward products
         for (int i = 0; i < 3; i++) begin
            b3_p_ff[i][0] <= XW'(b2_l_ff[NXT[i]]) * XW'(b2_f_ff[PRV[i]]);
            b3_p_ff[i][1] <= XW'(b2_l_ff[PRV[i]]) * XW'(b2_f_ff[NXT[i]]);
            b3_l_ff[i] <= b2_l_ff[i];
            b3_f_ff[i] <= b2_f_ff[i];
            b3_fr_ff[i] <= b2_fr_ff[i];
         end
         b3_dg_ff <= b2_dg_ff;
         // trueup
         for (int i = 0; i < 3; i++) begin
            b4_t_ff[i] <= RW'(d3_in[i] >>> FRACTION_BITS);
            b4_l_ff[i] <= b3_l_ff[i];
            b4_f_ff[i] <= b3_f_ff[i];
            b4_fr_ff[i] <= b3_fr_ff[i];
         end
         b4_dg_ff <= b3_dg_ff;
         // row times eye products
         for (int k = 0; k < 3; k++) begin
            for (int i = 0; i < 3; i++) begin
               b5_r_ff[k][i] <= row_in[k][i];
               b5_tr_ff[k][i] <= TW'(row_in[k][i]) * TW'(b4_fr_ff[i]);
            end
         end
         b5_dg_ff <= b4_dg_ff;
         // negate, saturate, zero a degenerate frame
         for (int k = 0; k < 3; k++) begin
            for (int i = 0; i < 3; i++) begin
               out_rows[k][i] <= b5_dg_ff ? '0 : sat32(64'(b5_r_ff[k][i]));
            end
            out_rows[k][3] <= b5_dg_ff ? '0 : sat32(-64'(sum_in[k]));
         end
         out_degen <= b5_dg_ff;
      end
   end

endmodule
